// ===== rtl/stack_with_remove_by_value_defines.svh =====
// Assertion macros for the bounded stack with remove-by-value.
// Used by the port checker; depends on nothing else.
`ifndef STACK_WITH_REMOVE_BY_VALUE_DEFINES_SVH
`define STACK_WITH_REMOVE_BY_VALUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/swr_pkg.sv =====
// Shared types and codes for the bounded stack with remove-by-value.
// Used by the channel interfaces, the top level and the port checker.
package swr_pkg;

	localparam int WORD_W    = 32;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int FILL_W    = 5;
	localparam int REMOVED_W = 4;
	localparam int CAP_W     = 5;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CMD_W-1:0]         cmd_t;
	typedef logic [STATUS_W-1:0]      status_t;
	typedef logic [FILL_W-1:0]        fill_t;
	typedef logic [REMOVED_W-1:0]     removed_t;
	typedef logic [CAP_W-1:0]         cap_t;

	localparam cmd_t CMD_PUSH   = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;
	localparam cmd_t CMD_SWAP   = 2'd2;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_FULL      = 3'd1;
	localparam status_t ST_EMPTY     = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_FEW       = 3'd4;

	localparam cap_t CAP_RESET = 5'd16;

endpackage

// ===== rtl/swr_req_if.sv =====
// Command channel of the bounded stack: valid/ready handshake with payload.
// Depends on swr_pkg for the payload types.
interface swr_req_if;

	logic            valid;
	logic            ready;
	swr_pkg::cmd_t   command;
	swr_pkg::word_t  value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);

endinterface

// ===== rtl/swr_rsp_if.sv =====
// Result channel of the bounded stack: valid/ready handshake with payload.
// Depends on swr_pkg for the payload types.
interface swr_rsp_if;

	logic               valid;
	logic               ready;
	swr_pkg::status_t   status;
	swr_pkg::fill_t     fill_count;
	swr_pkg::removed_t  removed_index;

	modport source (output valid, output status, output fill_count, output removed_index,
		input ready);
	modport sink   (input valid, input status, input fill_count, input removed_index,
		output ready);

endinterface

// ===== rtl/stack_with_remove_by_value.sv =====
// Bounded stack of signed 32-bit words with push, remove-by-value and swap-ends.
// Depends on swr_pkg, swr_req_if and swr_rsp_if.
//
// A command transfers on req when valid and ready are high; ready is high only
// while the sequencer is idle. Each command returns one result on rsp (status,
// fill count after the command, index of the removed entry).
// From the command transfer, a push, and any command that fails at once, goes
// straight to the done state; a swap passes through SWAP_A, SWAP_B and SWAP_C;
// a remove passes through the scan and shift states. The remove path is one read
// of the storage read port per cycle: a scan from the bottom to the first match,
// then a shift of every entry above it down by one. The next command can be taken once the result is loaded.
// The result sits in an output register until the receiver takes it; the
// next command is accepted meanwhile, and its own result waits in the done
// state until the register frees up.
// cfg_we writes the capacity; it must only be written while the block is idle.
// Reset clears the fill count, sets the capacity to 16 and drops rsp.valid;
// the storage itself is not cleared, and only entries below the count are read.
module stack_with_remove_by_value #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	swr_req_if.sink       req,
	swr_rsp_if.source     rsp,
	input  logic          cfg_we,
	input  swr_pkg::cap_t cfg_wdata
);
	import swr_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_SWAP_A = 3'd3;
	localparam logic [2:0] S_SWAP_B = 3'd4;
	localparam logic [2:0] S_SWAP_C = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	status_t       status_q, status_d;
	removed_t      removed_q, removed_d;
	cap_t          cap_q;
	word_t         value_q, value_d;
	word_t         tmp_q, tmp_d;

	word_t         entries_q [DEPTH];
	word_t         rd_data_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	word_t         wr_data;

	logic          rsp_valid_q;
	status_t       rsp_status_q;
	fill_t         rsp_fill_q;
	removed_t      rsp_removed_q;
	logic          load_out;

	logic [CW-1:0] idx_next, idx_prev, top_idx;
	logic          more, full;

	assign idx_next = idx_q + CW'(1);
	assign idx_prev = idx_q - CW'(1);
	assign top_idx  = count_q - CW'(1);
	assign more     = idx_next < count_q;
	assign full     = (count_q >= CW'(DEPTH)) || (CMPW'(count_q) >= CMPW'(cap_q));

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.fill_count    = rsp_fill_q;
	assign rsp.removed_index = rsp_removed_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		status_d  = status_q;
		removed_d = removed_q;
		value_d   = value_q;
		tmp_d     = tmp_q;
		rd_en     = 1'b0;
		rd_addr   = idx_next[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = idx_prev[AW-1:0];
		wr_data   = rd_data_q;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					value_d   = req.value;
					status_d  = ST_OK;
					removed_d = '0;
					idx_d     = '0;
					state_d   = S_DONE;
					unique case (req.command)
						CMD_PUSH: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = count_q[AW-1:0];
								wr_data = req.value;
								count_d = count_q + CW'(1);
							end
						end
						CMD_REMOVE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								state_d = S_SCAN;
							end
						end
						CMD_SWAP: begin
							if (count_q < CW'(2)) begin
								status_d = ST_FEW;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								state_d = S_SWAP_A;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (rd_data_q == value_q) begin
					removed_d = REMOVED_W'(idx_q);
					if (more) begin
						rd_en   = 1'b1;
						idx_d   = idx_next;
						state_d = S_SHIFT;
					end else begin
						count_d = count_q - CW'(1);
						state_d = S_DONE;
					end
				end else if (more) begin
					rd_en = 1'b1;
					idx_d = idx_next;
				end else begin
					status_d = ST_NOT_FOUND;
					state_d  = S_DONE;
				end
			end
			S_SHIFT: begin
				wr_en = 1'b1;
				if (more) begin
					rd_en = 1'b1;
					idx_d = idx_next;
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_DONE;
				end
			end
			S_SWAP_A: begin
				tmp_d   = rd_data_q;
				rd_en   = 1'b1;
				rd_addr = top_idx[AW-1:0];
				state_d = S_SWAP_B;
			end
			S_SWAP_B: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				state_d = S_SWAP_C;
			end
			S_SWAP_C: begin
				wr_en   = 1'b1;
				wr_addr = top_idx[AW-1:0];
				wr_data = tmp_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			status_q    <= ST_OK;
			removed_q   <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			idx_q     <= idx_d;
			status_q  <= status_d;
			removed_q <= removed_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		tmp_q   <= tmp_d;
		if (load_out) begin
			rsp_status_q  <= status_q;
			rsp_fill_q    <= FILL_W'(count_q);
			rsp_removed_q <= removed_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= entries_q[rd_addr];
		end
	end

endmodule

// ===== rtl/swr_checker.sv =====
// Port checker for the bounded stack, attached to the top level by bind.
// Depends on swr_pkg and stack_with_remove_by_value_defines.svh.
`include "stack_with_remove_by_value_defines.svh"

module swr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input swr_pkg::status_t    rsp_status,
	input swr_pkg::fill_t      rsp_fill_count,
	input swr_pkg::removed_t   rsp_removed_index
);
	import swr_pkg::*;

	// A stalled result must hold its value and stay valid.
	`SWR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_fill_count) && $stable(rsp_removed_index), "result changed while stalled")

	// The block is busy in the cycle after every command transfer.
	`SWR_ASSERT_NEXT(a_busy_after_cmd, clk, arst_n, req_valid && req_ready, !req_ready, "command taken back to back")

	// Only a successful remove reports a nonzero index.
	`SWR_ASSERT_SAME(a_index_ok_only, clk, arst_n, rsp_valid && (rsp_removed_index != '0), rsp_status == ST_OK, "removed index on a failed command")

	// An empty status means the stack holds nothing.
	`SWR_ASSERT_SAME(a_empty_count, clk, arst_n, rsp_valid && (rsp_status == ST_EMPTY), rsp_fill_count == '0, "empty status with entries held")

endmodule

bind stack_with_remove_by_value swr_checker u_swr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_fill_count    (rsp.fill_count),
	.rsp_removed_index (rsp.removed_index)
);
